[hw/rtl/ray_two_disk_nearest_hit_unit_defines.svh]
// Assertion macros shared by the ray/disk hit unit RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef RAY_TWO_DISK_NEAREST_HIT_UNIT_DEFINES_SVH
`define RAY_TWO_DISK_NEAREST_HIT_UNIT_DEFINES_SVH

// cond implies cons in the same cycle
`define RTDNH_ASSERT_IMPL(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// cond never holds
`define RTDNH_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

[hw/rtl/rtdnh_pkg.sv]
// Types and constants of the ray/disk nearest hit unit.
// No dependencies; used by every module of the unit.
package rtdnh_pkg;

    localparam int COORD_W    = 16;
    localparam int NORM_W     = 16;
    localparam int RAD_W      = 16;
    localparam int DIST_W     = 32;
    localparam int FRAC_SHIFT = 22;
    localparam int OVF_SHIFT  = DIST_W - FRAC_SHIFT;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PN_W       = DIFF_W + NORM_W;
    localparam int PD_W       = 2 * NORM_W;
    localparam int NUM_W      = PN_W + 2;
    localparam int DEN_W      = PD_W + 2;
    localparam int REM_W      = DEN_W + DIST_W;
    localparam int MUL_W      = DIST_W + 1 + NORM_W;
    localparam int OFF_W      = MUL_W - 14;
    localparam int ABS_W      = 25;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int CFG_W      = 3 * COORD_W;
    localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(1) << 24;

    typedef enum logic [2:0] {
        CFG_A_CENTER = 3'd0,
        CFG_A_NORMAL = 3'd1,
        CFG_A_RADIUS = 3'd2,
        CFG_B_CENTER = 3'd3,
        CFG_B_NORMAL = 3'd4,
        CFG_B_RADIUS = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [NORM_W-1:0]  dir_x;
        logic signed [NORM_W-1:0]  dir_y;
        logic signed [NORM_W-1:0]  dir_z;
        logic [DIST_W-1:0]         dist_limit;
    } t_ray_in;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic              is_disk_a;
    } t_hit_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nz;
        logic [RAD_W-1:0]          radius;
    } t_disk;

    typedef struct packed {
        t_ray_in ray;
        logic    live;
    } t_div_side;

endpackage

[hw/rtl/rtdnh_front.sv]
// Front end of one disk test: dot products, sums, magnitudes and early miss flags.
// Depends on rtdnh_pkg.
module rtdnh_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  rtdnh_pkg::t_ray_in         i_ray,
    input  rtdnh_pkg::t_disk           i_disk,
    output logic                       o_valid,
    output logic [rtdnh_pkg::NUM_W-1:0] o_num_abs,
    output logic [rtdnh_pkg::DEN_W-1:0] o_den_abs,
    output rtdnh_pkg::t_div_side       o_side
);
    import rtdnh_pkg::*;

    logic                   r_v1, r_v2, r_v3;
    t_ray_in                r_ray1, r_ray2;
    logic signed [PN_W-1:0] r_pn [3];
    logic signed [PD_W-1:0] r_pd [3];
    logic signed [PN_W-1:0] n_pn [3];
    logic signed [PD_W-1:0] n_pd [3];
    logic signed [DIFF_W-1:0] n_d [3];
    logic signed [NUM_W-1:0] r_num;
    logic signed [DEN_W-1:0] r_den;
    logic [NUM_W-1:0]       n_num_abs;
    logic [DEN_W-1:0]       n_den_abs;
    logic                   n_live;

    always_comb begin
        n_d[0] = i_disk.cx - i_ray.origin_x;
        n_d[1] = i_disk.cy - i_ray.origin_y;
        n_d[2] = i_disk.cz - i_ray.origin_z;
        n_pn[0] = i_disk.nx * n_d[0];
        n_pn[1] = i_disk.ny * n_d[1];
        n_pn[2] = i_disk.nz * n_d[2];
        n_pd[0] = i_disk.nx * i_ray.dir_x;
        n_pd[1] = i_disk.ny * i_ray.dir_y;
        n_pd[2] = i_disk.nz * i_ray.dir_z;
    end

    always_comb begin
        n_num_abs = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
        n_den_abs = r_den[DEN_W-1] ? DEN_W'(-r_den) : DEN_W'(r_den);
        n_live = (r_den != '0) && (r_num != '0) && (r_num[NUM_W-1] == r_den[DEN_W-1])
            && ((DEN_W + OVF_SHIFT)'(n_num_abs) < {n_den_abs, OVF_SHIFT'(0)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_ray1 <= i_ray;
        r_pn   <= n_pn;
        r_pd   <= n_pd;
        r_ray2 <= r_ray1;
        r_num  <= r_pn[0] + r_pn[1] + r_pn[2];
        r_den  <= r_pd[0] + r_pd[1] + r_pd[2];
        o_side.ray  <= r_ray2;
        o_side.live <= n_live;
        o_num_abs   <= n_num_abs;
        o_den_abs   <= n_den_abs;
    end

    assign o_valid = r_v3;

endmodule

[hw/rtl/rtdnh_div.sv]
// Pipelined restoring divider, one quotient bit per stage, quotient below 2^DIST_W.
// Depends on rtdnh_pkg.
module rtdnh_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [rtdnh_pkg::NUM_W-1:0] i_num_abs,
    input  logic [rtdnh_pkg::DEN_W-1:0] i_den_abs,
    input  rtdnh_pkg::t_div_side        i_side,
    output logic                        o_valid,
    output logic [rtdnh_pkg::DIST_W-1:0] o_quo,
    output rtdnh_pkg::t_div_side        o_side
);
    import rtdnh_pkg::*;

    logic [DIST_W-1:0] r_vld;
    logic [REM_W-1:0]  r_rem  [DIST_W];
    logic [DEN_W-1:0]  r_den  [DIST_W];
    logic [DIST_W-1:0] r_quo  [DIST_W];
    t_div_side         r_side [DIST_W];
    logic [REM_W-1:0]  n_rem  [DIST_W];
    logic [DIST_W-1:0] n_quo  [DIST_W];
    logic [REM_W-1:0]  src_rem  [DIST_W];
    logic [DEN_W-1:0]  src_den  [DIST_W];
    logic [DIST_W-1:0] src_quo  [DIST_W];
    t_div_side         src_side [DIST_W];

    always_comb begin
        src_rem[0]  = REM_W'({i_num_abs, FRAC_SHIFT'(0)});
        src_den[0]  = i_den_abs;
        src_quo[0]  = '0;
        src_side[0] = i_side;
        for (int i = 1; i < DIST_W; i++) begin
            src_rem[i]  = r_rem[i-1];
            src_den[i]  = r_den[i-1];
            src_quo[i]  = r_quo[i-1];
            src_side[i] = r_side[i-1];
        end
    end

    always_comb begin
        logic [REM_W:0] trial;
        for (int i = 0; i < DIST_W; i++) begin
            trial = {1'b0, src_rem[i]} - ((REM_W + 1)'(src_den[i]) << (DIST_W - 1 - i));
            n_rem[i] = trial[REM_W] ? src_rem[i] : trial[REM_W-1:0];
            n_quo[i] = {src_quo[i][DIST_W-2:0], ~trial[REM_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DIST_W-2:0], i_valid};
        end
        for (int i = 0; i < DIST_W; i++) begin
            r_rem[i]  <= n_rem[i];
            r_quo[i]  <= n_quo[i];
            r_den[i]  <= src_den[i];
            r_side[i] <= src_side[i];
        end
    end

    assign o_valid = r_vld[DIST_W-1];
    assign o_quo   = r_quo[DIST_W-1];
    assign o_side  = r_side[DIST_W-1];

endmodule

[hw/rtl/rtdnh_back.sv]
// Back end of one disk test: range check of t, hit point offsets and radius test.
// Depends on rtdnh_pkg.
module rtdnh_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [rtdnh_pkg::DIST_W-1:0] i_quo,
    input  rtdnh_pkg::t_div_side         i_side,
    input  rtdnh_pkg::t_disk             i_disk,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [rtdnh_pkg::DIST_W-1:0] o_dist
);
    import rtdnh_pkg::*;

    logic                     r_v1, r_v2, r_v3, r_v4;
    logic                     r_ok1, r_ok2, r_ok3;
    logic [DIST_W-1:0]        r_q1, r_q2, r_q3;
    logic signed [MUL_W-1:0]  r_m [3];
    logic signed [DIFF_W-1:0] r_e [3];
    logic signed [MUL_W-1:0]  n_m [3];
    logic signed [DIFF_W-1:0] n_e [3];
    logic signed [OFF_W-1:0]  n_off [3];
    logic [OFF_W-1:0]         n_abs [3];
    logic [ABS_W-1:0]         r_abs [3];
    logic [SQ_W-1:0]          r_sq [3];
    logic [2*RAD_W-1:0]       r_rr;
    logic                     n_ok1, n_far;
    logic [SUM_W-1:0]         n_sum;

    always_comb begin
        n_ok1 = i_side.live && (i_quo != '0) && (i_quo <= i_side.ray.dist_limit);
        n_e[0] = i_side.ray.origin_x - i_disk.cx;
        n_e[1] = i_side.ray.origin_y - i_disk.cy;
        n_e[2] = i_side.ray.origin_z - i_disk.cz;
        n_m[0] = $signed({1'b0, i_quo}) * i_side.ray.dir_x;
        n_m[1] = $signed({1'b0, i_quo}) * i_side.ray.dir_y;
        n_m[2] = $signed({1'b0, i_quo}) * i_side.ray.dir_z;
    end

    always_comb begin
        n_far = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_off[i] = OFF_W'((MUL_W'(r_e[i]) <<< 8) + (r_m[i] >>> 14));
            n_abs[i] = n_off[i][OFF_W-1] ? OFF_W'(-n_off[i]) : OFF_W'(n_off[i]);
            if (n_abs[i] > OFF_LIMIT) begin
                n_far = 1'b1;
            end
        end
        n_sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_ok1 <= n_ok1;
        r_q1  <= i_quo;
        r_m   <= n_m;
        r_e   <= n_e;
        r_ok2 <= r_ok1 && !n_far;
        r_q2  <= r_q1;
        for (int i = 0; i < 3; i++) begin
            r_abs[i] <= n_abs[i][ABS_W-1:0];
            r_sq[i]  <= r_abs[i] * r_abs[i];
        end
        r_ok3 <= r_ok2;
        r_q3  <= r_q2;
        r_rr  <= i_disk.radius * i_disk.radius;
        o_hit  <= r_ok3 && (n_sum <= SUM_W'({r_rr, 16'h0000}));
        o_dist <= r_q3;
    end

    assign o_valid = r_v4;

endmodule

[hw/rtl/ray_two_disk_nearest_hit_unit.sv]
// Ray test against two configured disks, nearest hit first, disk A on a tie.
// Pipeline from an accepted start to o_done: front end, divider, back end and merge register.
// Throughput: one ray per cycle; o_busy stays low, set by the one-bit-per-stage divider.
// Reset: synchronous active-low i_rst_n clears all valid bits and the disk registers.
// Results are not back-pressured: o_done marks each transaction for one cycle.
`include "ray_two_disk_nearest_hit_unit_defines.svh"
module ray_two_disk_nearest_hit_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  rtdnh_pkg::t_ray_in          i_ray,
    output logic                        o_done,
    output rtdnh_pkg::t_hit_out         o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  rtdnh_pkg::t_cfg_idx         i_cfg_index,
    input  logic [rtdnh_pkg::CFG_W-1:0] i_cfg_data
);
    import rtdnh_pkg::*;

    logic [CFG_W-1:0] r_a_center, r_a_normal, r_b_center, r_b_normal;
    logic [RAD_W-1:0] r_a_radius, r_b_radius;
    t_disk            disk_a, disk_b;
    logic             accept;

    logic                fa_valid, fb_valid, da_valid, db_valid, ba_valid, bb_valid;
    logic [NUM_W-1:0]    fa_num, fb_num;
    logic [DEN_W-1:0]    fa_den, fb_den;
    t_div_side           fa_side, fb_side, da_side, db_side;
    logic [DIST_W-1:0]   da_quo, db_quo, ba_dist, bb_dist;
    logic                ba_hit, bb_hit;
    logic                r_done;
    t_hit_out            r_result, n_result;

    assign accept      = i_start && !o_busy;
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_center <= '0;
            r_a_normal <= '0;
            r_a_radius <= '0;
            r_b_center <= '0;
            r_b_normal <= '0;
            r_b_radius <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_A_CENTER: r_a_center <= i_cfg_data;
                CFG_A_NORMAL: r_a_normal <= i_cfg_data;
                CFG_A_RADIUS: r_a_radius <= i_cfg_data[RAD_W-1:0];
                CFG_B_CENTER: r_b_center <= i_cfg_data;
                CFG_B_NORMAL: r_b_normal <= i_cfg_data;
                CFG_B_RADIUS: r_b_radius <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        disk_a.cx     = r_a_center[COORD_W-1:0];
        disk_a.cy     = r_a_center[2*COORD_W-1:COORD_W];
        disk_a.cz     = r_a_center[3*COORD_W-1:2*COORD_W];
        disk_a.nx     = r_a_normal[NORM_W-1:0];
        disk_a.ny     = r_a_normal[2*NORM_W-1:NORM_W];
        disk_a.nz     = r_a_normal[3*NORM_W-1:2*NORM_W];
        disk_a.radius = r_a_radius;
        disk_b.cx     = r_b_center[COORD_W-1:0];
        disk_b.cy     = r_b_center[2*COORD_W-1:COORD_W];
        disk_b.cz     = r_b_center[3*COORD_W-1:2*COORD_W];
        disk_b.nx     = r_b_normal[NORM_W-1:0];
        disk_b.ny     = r_b_normal[2*NORM_W-1:NORM_W];
        disk_b.nz     = r_b_normal[3*NORM_W-1:2*NORM_W];
        disk_b.radius = r_b_radius;
    end

    rtdnh_front u_front_a (
        .i_clk, .i_rst_n, .i_valid(accept), .i_ray, .i_disk(disk_a),
        .o_valid(fa_valid), .o_num_abs(fa_num), .o_den_abs(fa_den), .o_side(fa_side)
    );
    rtdnh_front u_front_b (
        .i_clk, .i_rst_n, .i_valid(accept), .i_ray, .i_disk(disk_b),
        .o_valid(fb_valid), .o_num_abs(fb_num), .o_den_abs(fb_den), .o_side(fb_side)
    );

    rtdnh_div u_div_a (
        .i_clk, .i_rst_n, .i_valid(fa_valid), .i_num_abs(fa_num), .i_den_abs(fa_den),
        .i_side(fa_side), .o_valid(da_valid), .o_quo(da_quo), .o_side(da_side)
    );
    rtdnh_div u_div_b (
        .i_clk, .i_rst_n, .i_valid(fb_valid), .i_num_abs(fb_num), .i_den_abs(fb_den),
        .i_side(fb_side), .o_valid(db_valid), .o_quo(db_quo), .o_side(db_side)
    );

    rtdnh_back u_back_a (
        .i_clk, .i_rst_n, .i_valid(da_valid), .i_quo(da_quo), .i_side(da_side),
        .i_disk(disk_a), .o_valid(ba_valid), .o_hit(ba_hit), .o_dist(ba_dist)
    );
    rtdnh_back u_back_b (
        .i_clk, .i_rst_n, .i_valid(db_valid), .i_quo(db_quo), .i_side(db_side),
        .i_disk(disk_b), .o_valid(bb_valid), .o_hit(bb_hit), .o_dist(bb_dist)
    );

    always_comb begin
        if (ba_hit && (!bb_hit || ba_dist <= bb_dist)) begin
            n_result = '{hit: 1'b1, distance: ba_dist, is_disk_a: 1'b1};
        end else if (bb_hit) begin
            n_result = '{hit: 1'b1, distance: bb_dist, is_disk_a: 1'b0};
        end else begin
            n_result = '{hit: 1'b0, distance: '0, is_disk_a: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ba_valid;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `RTDNH_ASSERT_IMPL(a_lanes_aligned, 1'b1, ba_valid == bb_valid, "disk lanes out of step")
    `RTDNH_ASSERT_IMPL(a_miss_clean, o_done && !o_result.hit,
        o_result.distance == '0 && !o_result.is_disk_a, "miss result not cleared")
    `RTDNH_ASSERT_IMPL(a_hit_nonzero, o_done && o_result.hit, o_result.distance != '0,
        "hit with zero distance")
    `RTDNH_ASSERT_NEVER(a_disk_a_hit, o_done && o_result.is_disk_a && !o_result.hit,
        "disk A flagged without hit")

endmodule

[sim/ray_two_disk_nearest_hit_checker.sv]
// Checker for the ray/disk nearest hit unit: mirrors the disk registers, predicts
// one hit result per accepted ray and compares each o_done transaction in order.
// Depends on rtdnh_pkg.
`timescale 1ns / 100ps
module ray_two_disk_nearest_hit_checker
    import rtdnh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_ray_in           i_ray,
    input  logic              i_done,
    input  t_hit_out          i_result,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_pending,
    output int                o_errors
);

    t_disk    disk_a;
    t_disk    disk_b;
    t_hit_out hits_due[$];

    initial o_errors = 0;
    assign o_pending = hits_due.size();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic logic disk_hit(input t_disk d, input t_ray_in r,
                                      output logic [DIST_W-1:0] t_hit);
        longint nrm[3];
        longint ctr[3];
        longint org[3];
        longint dir[3];
        longint den;
        longint num;
        longint q;
        longint off;
        longint sum;
        longint rr;
        nrm = '{longint'(d.nx), longint'(d.ny), longint'(d.nz)};
        ctr = '{longint'(d.cx), longint'(d.cy), longint'(d.cz)};
        org = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
        dir = '{longint'(r.dir_x), longint'(r.dir_y), longint'(r.dir_z)};
        den = 0;
        num = 0;
        sum = 0;
        t_hit = '0;
        for (int i = 0; i < 3; i++) begin
            den += nrm[i] * dir[i];
            num += nrm[i] * (ctr[i] - org[i]);
        end
        if (den == 0 || num == 0 || ((num < 0) != (den < 0)))
            return 1'b0;
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        q = (num << 22) / den;
        if (q == 0 || q > longint'(r.dist_limit))
            return 1'b0;
        for (int i = 0; i < 3; i++) begin
            off = (org[i] - ctr[i]) * 256 + ((q * dir[i]) >>> 14);
            if (off > (64'sd1 << 24) || off < -(64'sd1 << 24))
                return 1'b0;
            sum += off * off;
        end
        rr = longint'(d.radius) * 256 * longint'(d.radius) * 256;
        if (sum > rr)
            return 1'b0;
        t_hit = q[DIST_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_hit_out nearest_hit(input t_ray_in r);
        t_hit_out          res;
        logic              ha;
        logic              hb;
        logic [DIST_W-1:0] ta;
        logic [DIST_W-1:0] tb;
        ha = disk_hit(disk_a, r, ta);
        hb = disk_hit(disk_b, r, tb);
        res = '0;
        if (ha && (!hb || ta <= tb)) begin
            res.hit = 1'b1;
            res.distance = ta;
            res.is_disk_a = 1'b1;
        end else if (hb) begin
            res.hit = 1'b1;
            res.distance = tb;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hit_out want;
        if (!i_rst_n) begin
            disk_a <= '0;
            disk_b <= '0;
            hits_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_A_CENTER: {disk_a.cz, disk_a.cy, disk_a.cx} <= i_cfg_data;
                    CFG_A_NORMAL: {disk_a.nz, disk_a.ny, disk_a.nx} <= i_cfg_data;
                    CFG_A_RADIUS: disk_a.radius <= i_cfg_data[RAD_W-1:0];
                    CFG_B_CENTER: {disk_b.cz, disk_b.cy, disk_b.cx} <= i_cfg_data;
                    CFG_B_NORMAL: {disk_b.nz, disk_b.ny, disk_b.nx} <= i_cfg_data;
                    CFG_B_RADIUS: disk_b.radius <= i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                hits_due.push_back(nearest_hit(i_ray));
            if (i_done) begin
                if (hits_due.size() == 0) begin
                    report_mismatch("unexpected transaction", i_result, 0);
                end else begin
                    want = hits_due.pop_front();
                    if (i_result.hit !== want.hit)
                        report_mismatch("hit", i_result.hit, want.hit);
                    if (i_result.distance !== want.distance)
                        report_mismatch("distance", i_result.distance, want.distance);
                    if (i_result.is_disk_a !== want.is_disk_a)
                        report_mismatch("is_disk_a", i_result.is_disk_a, want.is_disk_a);
                end
            end
        end
    end

endmodule

[sim/tb_ray_two_disk_nearest_hit_unit.sv]
// Testbench top of the ray/disk nearest hit unit: drives rays and disk settings,
// gives the verdict. Depends on rtdnh_pkg, the unit and ray_two_disk_nearest_hit_checker.
`timescale 1ns / 100ps
module tb_ray_two_disk_nearest_hit_unit;
    import rtdnh_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_start = 1'b0;
    logic             o_busy;
    t_ray_in          i_ray = '0;
    logic             o_done;
    t_hit_out         o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    t_cfg_idx         i_cfg_index = CFG_A_CENTER;
    logic [CFG_W-1:0] i_cfg_data = '0;
    int               pending;
    int               errors;
    int               idle_cycles = 0;
    logic             no_gaps = 1'b0;
    t_disk            cur_a = '0;
    t_disk            cur_b = '0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    ray_two_disk_nearest_hit_unit uut (.*);

    ray_two_disk_nearest_hit_checker checker_i (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_ray, .i_done(o_done),
        .i_result(o_result), .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .o_pending(pending), .o_errors(errors)
    );

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_ray(input t_ray_in r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_ray <= r;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        repeat ($urandom_range(0, 9)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    // program both disks; junk goes in the unused radius bits and to unmapped indexes
    task automatic load_disks(input t_disk a, input t_disk b);
        logic [CFG_W-RAD_W-1:0] junk;
        junk = $urandom;
        drain();
        write_reg(CFG_A_CENTER, {a.cz, a.cy, a.cx});
        write_reg(CFG_A_NORMAL, {a.nz, a.ny, a.nx});
        write_reg(CFG_A_RADIUS, {junk, a.radius});
        write_reg(CFG_B_CENTER, {b.cz, b.cy, b.cx});
        write_reg(CFG_B_NORMAL, {b.nz, b.ny, b.nx});
        write_reg(CFG_B_RADIUS, {~junk, b.radius});
        write_reg(t_cfg_idx'(3'($urandom_range(6, 7))), {16'($urandom), $urandom});
        cur_a = a;
        cur_b = b;
        no_gaps = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic [NORM_W-1:0] pick_normal();
        case ($urandom_range(0, 4))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom_range(0, 3000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_disk random_disk();
        t_disk d;
        d = {$urandom, $urandom, $urandom, 16'($urandom)};
        d.nx = pick_normal();
        d.ny = pick_normal();
        d.nz = pick_normal();
        if ($urandom_range(0, 1)) d.radius = 16'($urandom_range(0, 16'h2000));
        return d;
    endfunction

    function automatic t_ray_in aimed_ray(input t_disk d);
        t_ray_in r;
        longint  tgt[3];
        longint  org[3];
        longint  diff[3];
        longint  m;
        logic signed [NORM_W-1:0] dv[3];
        r = {$urandom, $urandom, $urandom, $urandom};
        tgt = '{longint'(d.cx) + $signed($urandom_range(0, 2048)) - 1024,
                longint'(d.cy) + $signed($urandom_range(0, 2048)) - 1024,
                longint'(d.cz) + $signed($urandom_range(0, 2048)) - 1024};
        org = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
        m = 1;
        for (int i = 0; i < 3; i++) begin
            diff[i] = tgt[i] - org[i];
            if (diff[i] > m) m = diff[i];
            if (-diff[i] > m) m = -diff[i];
        end
        for (int i = 0; i < 3; i++) dv[i] = NORM_W'(diff[i] * 16383 / m);
        r.dir_x = dv[0];
        r.dir_y = dv[1];
        r.dir_z = dv[2];
        if ($urandom_range(0, 3) != 0) r.dist_limit = '1;
        return r;
    endfunction

    task automatic random_rays(input int count);
        t_ray_in r;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0, 1:    r = {$urandom, $urandom, $urandom, $urandom};
                2, 3, 4: r = aimed_ray(cur_b);
                default: r = aimed_ray(cur_a);
            endcase
            if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
            send_ray(r);
        end
    endtask

    function automatic t_ray_in mk_ray(input logic [15:0] ox, oy, oz, dx, dy, dz,
                                       input logic [31:0] maxd);
        return {ox, oy, oz, dx, dy, dz, maxd};
    endfunction

    initial begin
        t_disk a;
        t_disk b;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        random_rays(50);

        a = '{cx: 0, cy: 0, cz: 16'sh0100, nx: 0, ny: 0, nz: 16'sd16384, radius: 16'h1000};
        b = a;
        b.nz = -16'sd16384;
        b.radius = 16'h0800;
        load_disks(a, b);
        send_ray(mk_ray(0, 0, 0, 0, 0, 16'sd16384, '1));
        send_ray(mk_ray(0, 0, 0, 16'sd16384, 0, 0, '1));
        send_ray(mk_ray(0, 0, 0, 0, 0, -16'sd16384, '1));
        send_ray(mk_ray(0, 0, 0, 0, 0, 16'sd16384, 32'd0));
        send_ray(mk_ray(0, 0, 0, 0, 0, 16'sd16384, 32'd65535));
        send_ray(mk_ray(0, 0, 0, 0, 0, 16'sd16384, 32'd65536));
        send_ray(mk_ray(0, 0, 16'h00FF, 0, 0, 16'h7FFF, '1));
        send_ray(mk_ray(0, 0, 16'h00FF, 0, 0, 16'h8000, '1));
        send_ray(mk_ray(0, 0, 16'h00FF, 0, 0, 16'sd1, '1));
        send_ray(mk_ray(0, 0, 0, 16'h7FFF, 0, 16'sd1, '1));
        send_ray(mk_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, '1));
        send_ray(mk_ray(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, '1));
        send_ray(mk_ray(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, '1));
        send_ray(mk_ray(16'h0400, 0, 0, 0, 0, 16'sd16384, '1));
        send_ray(mk_ray(16'h1000, 0, 0, 0, 0, 16'sd16384, '1));
        send_ray(mk_ray(16'h1001, 0, 0, 0, 0, 16'sd16384, '1));
        random_rays(250);

        a = '{cx: 16'h7FFF, cy: 16'h8000, cz: 16'h7FFF, nx: 16'h8000, ny: 16'h7FFF,
              nz: 16'h8000, radius: 16'hFFFF};
        b = '{cx: 16'h8000, cy: 16'h7FFF, cz: 16'h8000, nx: 16'h7FFF, ny: 16'h8000,
              nz: 16'h7FFF, radius: 16'h0000};
        load_disks(a, b);
        random_rays(250);

        for (int p = 0; p < 5; p++) begin
            a = random_disk();
            b = (p == 2) ? a : random_disk();
            load_disks(a, b);
            random_rays(250);
        end

        drain();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
